// ===== rtl/core/bis_pkg.sv =====
// Shared types, constants and codes of the bilinear image scaler.
`default_nettype none

package bis_pkg;

    localparam int MAX_IMAGE_WIDTH_DEF    = 256;
    localparam int MAX_IMAGE_HEIGHT_DEF   = 256;
    localparam int STEP_FRACTION_BITS_DEF = 16;

    localparam int COORD_W    = 12;
    localparam int STEP_W     = 24;
    localparam int CHAN_W     = 8;
    localparam int PIXEL_W    = 3 * CHAN_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int ORIGIN_W   = 8;
    localparam int SIZE_W     = 9;
    localparam int NEIGH_N    = 4;

    localparam logic [SIZE_W-1:0] REGION_WIDTH_RST  = 9'd256;
    localparam logic [SIZE_W-1:0] REGION_HEIGHT_RST = 9'd256;
    localparam logic [STEP_W-1:0] STEP_ONE_RST      = 24'd65536;
    localparam logic [SIZE_W-1:0] IMAGE_WIDTH_RST   = 9'd256;
    localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RST  = 9'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGION_LEFT   = 3'd0,
        CFG_REGION_TOP    = 3'd1,
        CFG_REGION_WIDTH  = 3'd2,
        CFG_REGION_HEIGHT = 3'd3,
        CFG_COLUMN_STEP   = 3'd4,
        CFG_ROW_STEP      = 3'd5,
        CFG_IMAGE_WIDTH   = 3'd6,
        CFG_IMAGE_HEIGHT  = 3'd7
    } cfg_index_t;

    typedef enum logic {
        MODE_WRITE   = 1'b0,
        MODE_REQUEST = 1'b1
    } mode_t;

    typedef struct packed {
        logic [ORIGIN_W-1:0] region_left;
        logic [ORIGIN_W-1:0] region_top;
        logic [SIZE_W-1:0]   region_width;
        logic [SIZE_W-1:0]   region_height;
        logic [STEP_W-1:0]   column_step;
        logic [STEP_W-1:0]   row_step;
        logic [SIZE_W-1:0]   image_width;
        logic [SIZE_W-1:0]   image_height;
    } cfg_t;

    typedef struct packed {
        logic               mode;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [CHAN_W-1:0]  red_in;
        logic [CHAN_W-1:0]  green_in;
        logic [CHAN_W-1:0]  blue_in;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
    } out_item_t;

    typedef enum logic [1:0] {
        LANE_HOLD  = 2'd0,
        LANE_H_TOP = 2'd1,
        LANE_H_BOT = 2'd2,
        LANE_VERT  = 2'd3
    } lane_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS_X,
        ST_POS_Y,
        ST_EDGE,
        ST_PLACE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_RD_LAST,
        ST_H_BOT,
        ST_VERT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/bilinear_image_scaler_unit.sv =====
// Top level of the bilinear image scaler: configuration, datapath and result register.
// A write beat (mode 0) stores one RGB888 source pixel, and the unit stays idle and
// ready for the next beat. A request beat (mode 1) walks the sequencer states in
// order up to a loaded result register, and the unit then returns to idle for the
// next beat: the position states multiply the destination column and row by the
// steps, the edge and place states clamp the neighbors to the region and check them
// against the image, the read states issue the four neighbor reads through the
// single port of the source memory (registered read) while the top row blend runs
// alongside the fourth read, a further state captures the last neighbor, the next
// states blend the bottom row and then vertically on three channel lanes, and the
// done state loads the result register. A finished result waits in the output
// register while later beats are taken; a second request waits in its final state
// until that register is free. Neighbors outside the image read as black; reading
// a pixel that was never written returns whatever the memory holds.
`default_nettype none

module bilinear_image_scaler_unit #(
    parameter int MAX_IMAGE_WIDTH    = bis_pkg::MAX_IMAGE_WIDTH_DEF,
    parameter int MAX_IMAGE_HEIGHT   = bis_pkg::MAX_IMAGE_HEIGHT_DEF,
    parameter int STEP_FRACTION_BITS = bis_pkg::STEP_FRACTION_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [bis_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bis_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire bis_pkg::in_item_t                 s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output bis_pkg::out_item_t                     m_data
);

    localparam int DEPTH = MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int F     = STEP_FRACTION_BITS;

    bis_pkg::cfg_t      cfg_reg;
    bis_pkg::out_item_t m_data_reg;
    logic               m_valid_reg;

    logic                         out_free;
    logic                         done;
    logic                         mem_wr_en;
    logic                         mem_rd_en;
    logic [AW-1:0]                mem_addr;
    logic [bis_pkg::PIXEL_W-1:0]  mem_wr_data;
    logic [bis_pkg::PIXEL_W-1:0]  mem_rd_data;
    bis_pkg::lane_op_t            lane_op;
    logic [bis_pkg::NEIGH_N-1:0][bis_pkg::PIXEL_W-1:0] nb;
    logic [F-1:0]                 frac_x;
    logic [F-1:0]                 frac_y;
    logic [2:0][bis_pkg::CHAN_W-1:0] lane_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.region_left   <= '0;
            cfg_reg.region_top    <= '0;
            cfg_reg.region_width  <= bis_pkg::REGION_WIDTH_RST;
            cfg_reg.region_height <= bis_pkg::REGION_HEIGHT_RST;
            cfg_reg.column_step   <= bis_pkg::STEP_ONE_RST;
            cfg_reg.row_step      <= bis_pkg::STEP_ONE_RST;
            cfg_reg.image_width   <= bis_pkg::IMAGE_WIDTH_RST;
            cfg_reg.image_height  <= bis_pkg::IMAGE_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (bis_pkg::cfg_index_t'(cfg_index))
                bis_pkg::CFG_REGION_LEFT:
                    cfg_reg.region_left <= cfg_wr_data[bis_pkg::ORIGIN_W-1:0];
                bis_pkg::CFG_REGION_TOP:
                    cfg_reg.region_top <= cfg_wr_data[bis_pkg::ORIGIN_W-1:0];
                bis_pkg::CFG_REGION_WIDTH:
                    cfg_reg.region_width <= cfg_wr_data[bis_pkg::SIZE_W-1:0];
                bis_pkg::CFG_REGION_HEIGHT:
                    cfg_reg.region_height <= cfg_wr_data[bis_pkg::SIZE_W-1:0];
                bis_pkg::CFG_COLUMN_STEP:
                    cfg_reg.column_step <= cfg_wr_data[bis_pkg::STEP_W-1:0];
                bis_pkg::CFG_ROW_STEP:
                    cfg_reg.row_step <= cfg_wr_data[bis_pkg::STEP_W-1:0];
                bis_pkg::CFG_IMAGE_WIDTH:
                    cfg_reg.image_width <= cfg_wr_data[bis_pkg::SIZE_W-1:0];
                bis_pkg::CFG_IMAGE_HEIGHT:
                    cfg_reg.image_height <= cfg_wr_data[bis_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    bis_ctrl #(
        .MAX_W (MAX_IMAGE_WIDTH),
        .MAX_H (MAX_IMAGE_HEIGHT),
        .F     (F),
        .AW    (AW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .out_free    (out_free),
        .done        (done),
        .mem_wr_en   (mem_wr_en),
        .mem_rd_en   (mem_rd_en),
        .mem_addr    (mem_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_data (mem_rd_data),
        .lane_op     (lane_op),
        .nb          (nb),
        .frac_x      (frac_x),
        .frac_y      (frac_y)
    );

    bis_pixel_mem #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .rd_en   (mem_rd_en),
        .addr    (mem_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic [bis_pkg::NEIGH_N-1:0][bis_pkg::CHAN_W-1:0] nb_chan;

        for (genvar n = 0; n < bis_pkg::NEIGH_N; n++) begin : g_nb
            assign nb_chan[n] = nb[n][bis_pkg::PIXEL_W-1-bis_pkg::CHAN_W*k -: bis_pkg::CHAN_W];
        end

        bis_blend_lane #(
            .F (F)
        ) u_lane (
            .aclk   (aclk),
            .op     (lane_op),
            .nb     (nb_chan),
            .frac_x (frac_x),
            .frac_y (frac_y),
            .result (lane_res[k])
        );
    end

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_data_reg.red_out   <= lane_res[0];
            m_data_reg.green_out <= lane_res[1];
            m_data_reg.blue_out  <= lane_res[2];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bis_pixel_mem.sv =====
// Source image memory: one port, synchronous write, registered read.
`default_nettype none

module bis_pixel_mem #(
    parameter int AW    = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                         aclk,
    input  wire logic                         wr_en,
    input  wire logic                         rd_en,
    input  wire logic [AW-1:0]                addr,
    input  wire logic [bis_pkg::PIXEL_W-1:0]  wr_data,
    output logic      [bis_pkg::PIXEL_W-1:0]  rd_data
);

    logic [bis_pkg::PIXEL_W-1:0] mem [DEPTH];
    logic [bis_pkg::PIXEL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bis_blend_lane.sv =====
// One color channel of the interpolator: horizontal blends then vertical blend.
`default_nettype none

module bis_blend_lane #(
    parameter int F = 16
) (
    input  wire logic                                           aclk,
    input  wire bis_pkg::lane_op_t                              op,
    input  wire logic [bis_pkg::NEIGH_N-1:0][bis_pkg::CHAN_W-1:0] nb,
    input  wire logic [F-1:0]                                   frac_x,
    input  wire logic [F-1:0]                                   frac_y,
    output logic      [bis_pkg::CHAN_W-1:0]                     result
);

    logic [bis_pkg::CHAN_W-1:0] h_top_reg;
    logic [bis_pkg::CHAN_W-1:0] h_bot_reg;
    logic [bis_pkg::CHAN_W-1:0] vert_reg;

    logic [bis_pkg::CHAN_W-1:0] a;
    logic [bis_pkg::CHAN_W-1:0] b;
    logic [F-1:0]               f;
    logic signed [bis_pkg::CHAN_W:0]   diff;
    logic signed [F:0]                 f_s;
    logic signed [F+bis_pkg::CHAN_W+1:0] prod;
    logic signed [F+bis_pkg::CHAN_W+1:0] prod_sh;
    logic [bis_pkg::CHAN_W-1:0] blend;

    always_comb begin
        case (op)
            bis_pkg::LANE_H_TOP: begin
                a = nb[0];
                b = nb[1];
                f = frac_x;
            end
            bis_pkg::LANE_H_BOT: begin
                a = nb[2];
                b = nb[3];
                f = frac_x;
            end
            bis_pkg::LANE_VERT: begin
                a = h_top_reg;
                b = h_bot_reg;
                f = frac_y;
            end
            default: begin
                a = h_top_reg;
                b = h_bot_reg;
                f = frac_y;
            end
        endcase
        // a + floor(f * (b - a) / 2^F) equals ((1 - f) * a + f * b) >> F
        diff    = $signed({1'b0, b}) - $signed({1'b0, a});
        f_s     = $signed({1'b0, f});
        prod    = f_s * diff;
        prod_sh = prod >>> F;
        blend   = a + prod_sh[bis_pkg::CHAN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        case (op)
            bis_pkg::LANE_H_TOP: h_top_reg <= blend;
            bis_pkg::LANE_H_BOT: h_bot_reg <= blend;
            bis_pkg::LANE_VERT:  vert_reg  <= blend;
            default: ;
        endcase
    end

    assign result = vert_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bis_ctrl.sv =====
// Request sequencer: source position, neighbor addressing, memory reads and writes.
`default_nettype none

module bis_ctrl #(
    parameter int MAX_W = 256,
    parameter int MAX_H = 256,
    parameter int F     = 16,
    parameter int AW    = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire bis_pkg::cfg_t                 cfg,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire bis_pkg::in_item_t             s_data,
    input  wire logic                          out_free,
    output logic                               done,
    output logic                               mem_wr_en,
    output logic                               mem_rd_en,
    output logic [AW-1:0]                      mem_addr,
    output logic [bis_pkg::PIXEL_W-1:0]        mem_wr_data,
    input  wire logic [bis_pkg::PIXEL_W-1:0]   mem_rd_data,
    output bis_pkg::lane_op_t                  lane_op,
    output logic [bis_pkg::NEIGH_N-1:0][bis_pkg::PIXEL_W-1:0] nb,
    output logic [F-1:0]                       frac_x,
    output logic [F-1:0]                       frac_y
);

    localparam int PW    = bis_pkg::COORD_W + bis_pkg::STEP_W;
    localparam int XW    = PW - F;
    localparam int IXW   = XW + 1;
    localparam int CW    = $clog2(MAX_W);
    localparam int RW    = $clog2(MAX_H);
    localparam int CMP_W = bis_pkg::COORD_W + 1;

    function automatic logic [AW-1:0] pix_addr(input logic [RW-1:0] r,
                                               input logic [CW-1:0] c);
        pix_addr = AW'(r) * AW'(MAX_W) + AW'(c);
    endfunction

    bis_pkg::state_t state_reg;
    bis_pkg::state_t state_next;

    logic [bis_pkg::COORD_W-1:0] col_reg;
    logic [bis_pkg::COORD_W-1:0] row_reg;
    logic [PW-1:0]               px_reg;
    logic [PW-1:0]               py_reg;
    logic [XW-1:0]               x1_reg;
    logic [XW-1:0]               y1_reg;
    logic [CW-1:0]               ix0_reg;
    logic [CW-1:0]               ix1_reg;
    logic [RW-1:0]               iy0_reg;
    logic [RW-1:0]               iy1_reg;
    logic [bis_pkg::NEIGH_N-1:0] ok_reg;
    logic [bis_pkg::NEIGH_N-1:0][bis_pkg::PIXEL_W-1:0] nb_reg;

    logic [XW-1:0]  x0;
    logic [XW-1:0]  y0;
    logic [IXW-1:0] x0p1;
    logic [IXW-1:0] y0p1;
    logic [XW-1:0]  x1_next;
    logic [XW-1:0]  y1_next;
    logic [IXW-1:0] ix0;
    logic [IXW-1:0] ix1;
    logic [IXW-1:0] iy0;
    logic [IXW-1:0] iy1;
    logic           cx0_ok;
    logic           cx1_ok;
    logic           ry0_ok;
    logic           ry1_ok;
    logic           wr_ok;
    logic           accept;

    assign x0 = px_reg[PW-1:F];
    assign y0 = py_reg[PW-1:F];

    always_comb begin
        x0p1    = IXW'(x0) + IXW'(1);
        y0p1    = IXW'(y0) + IXW'(1);
        x1_next = (x0p1 >= IXW'(cfg.region_width))  ? x0 : x0p1[XW-1:0];
        y1_next = (y0p1 >= IXW'(cfg.region_height)) ? y0 : y0p1[XW-1:0];
        ix0     = IXW'(cfg.region_left) + IXW'(x0);
        ix1     = IXW'(cfg.region_left) + IXW'(x1_reg);
        iy0     = IXW'(cfg.region_top) + IXW'(y0);
        iy1     = IXW'(cfg.region_top) + IXW'(y1_reg);
        cx0_ok  = (ix0 < IXW'(cfg.image_width))  && (ix0 < IXW'(MAX_W));
        cx1_ok  = (ix1 < IXW'(cfg.image_width))  && (ix1 < IXW'(MAX_W));
        ry0_ok  = (iy0 < IXW'(cfg.image_height)) && (iy0 < IXW'(MAX_H));
        ry1_ok  = (iy1 < IXW'(cfg.image_height)) && (iy1 < IXW'(MAX_H));
        wr_ok   = (CMP_W'(s_data.column) < CMP_W'(cfg.image_width))
               && (CMP_W'(s_data.column) < CMP_W'(MAX_W))
               && (CMP_W'(s_data.row) < CMP_W'(cfg.image_height))
               && (CMP_W'(s_data.row) < CMP_W'(MAX_H));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bis_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        accept      = 1'b0;
        done        = 1'b0;
        mem_wr_en   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_addr    = pix_addr(iy0_reg, ix0_reg);
        mem_wr_data = {s_data.red_in, s_data.green_in, s_data.blue_in};
        lane_op     = bis_pkg::LANE_HOLD;
        case (state_reg)
            bis_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                accept   = s_valid;
                mem_addr = pix_addr(s_data.row[RW-1:0], s_data.column[CW-1:0]);
                if (s_valid) begin
                    if (s_data.mode == bis_pkg::MODE_REQUEST) begin
                        state_next = bis_pkg::ST_POS_X;
                    end else begin
                        mem_wr_en = wr_ok;
                    end
                end
            end
            bis_pkg::ST_POS_X: state_next = bis_pkg::ST_POS_Y;
            bis_pkg::ST_POS_Y: state_next = bis_pkg::ST_EDGE;
            bis_pkg::ST_EDGE:  state_next = bis_pkg::ST_PLACE;
            bis_pkg::ST_PLACE: state_next = bis_pkg::ST_RD0;
            bis_pkg::ST_RD0: begin
                mem_rd_en  = ok_reg[0];
                mem_addr   = pix_addr(iy0_reg, ix0_reg);
                state_next = bis_pkg::ST_RD1;
            end
            bis_pkg::ST_RD1: begin
                mem_rd_en  = ok_reg[1];
                mem_addr   = pix_addr(iy0_reg, ix1_reg);
                state_next = bis_pkg::ST_RD2;
            end
            bis_pkg::ST_RD2: begin
                mem_rd_en  = ok_reg[2];
                mem_addr   = pix_addr(iy1_reg, ix0_reg);
                state_next = bis_pkg::ST_RD3;
            end
            bis_pkg::ST_RD3: begin
                mem_rd_en  = ok_reg[3];
                mem_addr   = pix_addr(iy1_reg, ix1_reg);
                lane_op    = bis_pkg::LANE_H_TOP;
                state_next = bis_pkg::ST_RD_LAST;
            end
            bis_pkg::ST_RD_LAST: state_next = bis_pkg::ST_H_BOT;
            bis_pkg::ST_H_BOT: begin
                lane_op    = bis_pkg::LANE_H_BOT;
                state_next = bis_pkg::ST_VERT;
            end
            bis_pkg::ST_VERT: begin
                lane_op    = bis_pkg::LANE_VERT;
                state_next = bis_pkg::ST_DONE;
            end
            bis_pkg::ST_DONE: begin
                done = out_free;
                if (out_free) begin
                    state_next = bis_pkg::ST_IDLE;
                end
            end
            default: state_next = bis_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            col_reg <= s_data.column;
            row_reg <= s_data.row;
        end
        if (state_reg == bis_pkg::ST_POS_X) begin
            px_reg <= PW'(col_reg) * PW'(cfg.column_step);
        end
        if (state_reg == bis_pkg::ST_POS_Y) begin
            py_reg <= PW'(row_reg) * PW'(cfg.row_step);
        end
        if (state_reg == bis_pkg::ST_EDGE) begin
            x1_reg <= x1_next;
            y1_reg <= y1_next;
        end
        if (state_reg == bis_pkg::ST_PLACE) begin
            ix0_reg <= ix0[CW-1:0];
            ix1_reg <= ix1[CW-1:0];
            iy0_reg <= iy0[RW-1:0];
            iy1_reg <= iy1[RW-1:0];
            ok_reg  <= {cx1_ok && ry1_ok, cx0_ok && ry1_ok,
                        cx1_ok && ry0_ok, cx0_ok && ry0_ok};
        end
        case (state_reg)
            bis_pkg::ST_RD1:     nb_reg[0] <= ok_reg[0] ? mem_rd_data : '0;
            bis_pkg::ST_RD2:     nb_reg[1] <= ok_reg[1] ? mem_rd_data : '0;
            bis_pkg::ST_RD3:     nb_reg[2] <= ok_reg[2] ? mem_rd_data : '0;
            bis_pkg::ST_RD_LAST: nb_reg[3] <= ok_reg[3] ? mem_rd_data : '0;
            default: ;
        endcase
    end

    assign nb     = nb_reg;
    assign frac_x = px_reg[F-1:0];
    assign frac_y = py_reg[F-1:0];

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the bilinear image scaler: directed script, then random phases.
`timescale 1ns / 1ps

module testbench;
    import bis_pkg::*;

    localparam int RANDOM_BEATS = 1950;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int FRAC         = STEP_FRACTION_BITS_DEF;

    typedef struct packed {
        logic [21:0] col0;
        logic [21:0] col1;
        logic [21:0] row0;
        logic [21:0] row1;
        logic [15:0] frac_x;
        logic [15:0] frac_y;
    } footprint_t;

    typedef struct {
        bit         is_cfg;
        cfg_index_t reg_sel;
        logic [23:0] value;
        in_item_t   beat;
        bit         typed;
        out_item_t  want;
    } script_row_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    in_item_t              s_data      = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    out_item_t             m_data;

    cfg_t        scaler_cfg;
    logic [23:0] source_image [0:65535];
    bit          written [0:65535];
    out_item_t   pending_pixels [$];
    script_row_t script [$];
    out_item_t   oldest;
    int          mismatches = 0;
    int          beats_done = 0;
    bit          idle_on    = 1'b1;
    int          stall_left = 0;
    int unsigned cycles     = 0;

    always #1 aclk = ~aclk;

    bilinear_image_scaler_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    function automatic int eff_dim(logic [SIZE_W-1:0] n, int cap);
        return (n > cap) ? cap : int'(n);
    endfunction

    function automatic bit in_image(logic [21:0] c, logic [21:0] r);
        return c < eff_dim(scaler_cfg.image_width, MAX_IMAGE_WIDTH_DEF) &&
               r < eff_dim(scaler_cfg.image_height, MAX_IMAGE_HEIGHT_DEF);
    endfunction

    function automatic logic [15:0] pixel_addr(logic [21:0] c, logic [21:0] r);
        return {r[7:0], c[7:0]};
    endfunction

    function automatic logic [23:0] fetch(logic [21:0] c, logic [21:0] r);
        return in_image(c, r) ? source_image[pixel_addr(c, r)] : 24'h0;
    endfunction

    function automatic footprint_t locate(in_item_t it);
        footprint_t  f;
        logic [35:0] pos_x;
        logic [35:0] pos_y;
        logic [20:0] x0, x1, y0, y1;
        pos_x = 36'(it.column) * 36'(scaler_cfg.column_step);
        pos_y = 36'(it.row) * 36'(scaler_cfg.row_step);
        x0 = 21'(pos_x >> FRAC);
        y0 = 21'(pos_y >> FRAC);
        x1 = x0 + 21'd1;
        if (x1 >= 21'(scaler_cfg.region_width)) x1 = x0;
        y1 = y0 + 21'd1;
        if (y1 >= 21'(scaler_cfg.region_height)) y1 = y0;
        f.col0   = 22'(scaler_cfg.region_left) + 22'(x0);
        f.col1   = 22'(scaler_cfg.region_left) + 22'(x1);
        f.row0   = 22'(scaler_cfg.region_top) + 22'(y0);
        f.row1   = 22'(scaler_cfg.region_top) + 22'(y1);
        f.frac_x = pos_x[15:0];
        f.frac_y = pos_y[15:0];
        return f;
    endfunction

    function automatic logic [7:0] blend(logic [7:0] a, logic [7:0] b, logic [15:0] frac);
        logic [31:0] acc;
        acc = (32'h10000 - 32'(frac)) * 32'(a) + 32'(frac) * 32'(b);
        return acc[23:16];
    endfunction

    function automatic out_item_t interpolate_pixel(in_item_t it);
        footprint_t  f;
        logic [23:0] p00, p10, p01, p11;
        logic [23:0] res;
        logic [7:0]  top_h, bot_h;
        f   = locate(it);
        p00 = fetch(f.col0, f.row0);
        p10 = fetch(f.col1, f.row0);
        p01 = fetch(f.col0, f.row1);
        p11 = fetch(f.col1, f.row1);
        for (int k = 0; k < 3; k++) begin
            top_h = blend(p00[8*k +: 8], p10[8*k +: 8], f.frac_x);
            bot_h = blend(p01[8*k +: 8], p11[8*k +: 8], f.frac_x);
            res[8*k +: 8] = blend(top_h, bot_h, f.frac_y);
        end
        return out_item_t'(res);
    endfunction

    function automatic int idle_span();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] pick_origin();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 8'($urandom_range(0, 4));
        if (r < 85) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [8:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 9'($urandom_range(1, 20));
        if (r < 60) return 9'd256;
        if (r < 66) return 9'd0;
        if (r < 70) return 9'd511;
        if (r < 80) return 9'($urandom_range(257, 511));
        return 9'($urandom_range(21, 255));
    endfunction

    function automatic logic [23:0] pick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return STEP_ONE_RST;
        if (r < 40) return 24'h0;
        if (r < 50) return 24'hFFFFFF;
        if (r < 75) return 24'($urandom_range(24'h1000, 24'h20000));
        return 24'($urandom_range(0, 24'hFFFFFF));
    endfunction

    function automatic logic [11:0] write_coord(int dim);
        if (dim > 0 && $urandom_range(0, 99) < 85)
            return 12'($urandom_range(0, ((dim < 40) ? dim : 40) - 1));
        return 12'($urandom_range(0, 4095));
    endfunction

    function automatic logic [11:0] request_coord(logic [23:0] step, int dim);
        longint lim;
        if (step == 0 || $urandom_range(0, 99) < 15) return 12'($urandom_range(0, 4095));
        lim = ((longint'((dim < 32) ? dim : 32) + 2) << FRAC) / step;
        if (lim > 4095) lim = 4095;
        return 12'($urandom_range(0, int'(lim)));
    endfunction

    function automatic void add_cfg(cfg_index_t sel, logic [23:0] value);
        script_row_t row;
        row.is_cfg  = 1'b1;
        row.reg_sel = sel;
        row.value   = value;
        row.beat    = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        script.push_back(row);
    endfunction

    function automatic void add_beat(mode_t m, logic [11:0] c, logic [11:0] r,
                                     logic [23:0] rgb, bit typed, logic [23:0] want);
        script_row_t row;
        row.is_cfg  = 1'b0;
        row.reg_sel = CFG_REGION_LEFT;
        row.value   = '0;
        row.beat    = in_item_t'({m, c, r, rgb});
        row.typed   = typed;
        row.want    = out_item_t'(want);
        script.push_back(row);
    endfunction

    task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
        $display("mismatch %s at cycle %0d: got %h expected %h", what, cycles, got, want);
        mismatches++;
    endtask

    task automatic absorb_beat(in_item_t it, bit typed, out_item_t want);
        if (it.mode == MODE_WRITE) begin
            if (in_image(it.column, it.row)) begin
                source_image[pixel_addr(it.column, it.row)] = {it.red_in, it.green_in, it.blue_in};
                written[pixel_addr(it.column, it.row)] = 1'b1;
            end
            beats_done++;
        end else begin
            pending_pixels.push_back(typed ? want : interpolate_pixel(it));
            beats_done++;
        end
    endtask

    task automatic offer_beat(in_item_t it, bit typed, out_item_t want);
        int gap;
        gap = (idle_on && $urandom_range(0, 99) < 30) ? idle_span() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        absorb_beat(it, typed, want);
    endtask

    task automatic fill_then_request(in_item_t it);
        footprint_t  f;
        in_item_t    w;
        logic [21:0] c, r;
        f = locate(it);
        for (int k = 0; k < 4; k++) begin
            c = k[0] ? f.col1 : f.col0;
            r = k[1] ? f.row1 : f.row0;
            if (in_image(c, r) && !written[pixel_addr(c, r)]) begin
                w.mode     = MODE_WRITE;
                w.column   = c[11:0];
                w.row      = r[11:0];
                w.red_in   = 8'($urandom_range(0, 255));
                w.green_in = 8'($urandom_range(0, 255));
                w.blue_in  = 8'($urandom_range(0, 255));
                offer_beat(w, 1'b0, '0);
            end
        end
        offer_beat(it, 1'b0, '0);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t sel, logic [23:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= sel;
        cfg_wr_data <= value;
        @(posedge aclk);
        case (sel)
            CFG_REGION_LEFT:   scaler_cfg.region_left   = value[ORIGIN_W-1:0];
            CFG_REGION_TOP:    scaler_cfg.region_top    = value[ORIGIN_W-1:0];
            CFG_REGION_WIDTH:  scaler_cfg.region_width  = value[SIZE_W-1:0];
            CFG_REGION_HEIGHT: scaler_cfg.region_height = value[SIZE_W-1:0];
            CFG_COLUMN_STEP:   scaler_cfg.column_step   = value[STEP_W-1:0];
            CFG_ROW_STEP:      scaler_cfg.row_step      = value[STEP_W-1:0];
            CFG_IMAGE_WIDTH:   scaler_cfg.image_width   = value[SIZE_W-1:0];
            CFG_IMAGE_HEIGHT:  scaler_cfg.image_height  = value[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic close_config();
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 99) < 25) begin
            m_ready <= 1'b0;
            stall_left = idle_span() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected pixel", m_data, 24'h0);
            end else begin
                oldest = pending_pixels.pop_front();
                if (m_data.red_out !== oldest.red_out)
                    report_mismatch("red_out", 24'(m_data.red_out), 24'(oldest.red_out));
                if (m_data.green_out !== oldest.green_out)
                    report_mismatch("green_out", 24'(m_data.green_out), 24'(oldest.green_out));
                if (m_data.blue_out !== oldest.blue_out)
                    report_mismatch("blue_out", 24'(m_data.blue_out), 24'(oldest.blue_out));
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL bilinear_image_scaler_unit");
            $finish;
        end
    end

    initial begin
        in_item_t it;
        bit       cfg_open;
        int       phase;
        int       phase_beats;

        scaler_cfg.region_left   = '0;
        scaler_cfg.region_top    = '0;
        scaler_cfg.region_width  = REGION_WIDTH_RST;
        scaler_cfg.region_height = REGION_HEIGHT_RST;
        scaler_cfg.column_step   = STEP_ONE_RST;
        scaler_cfg.row_step      = STEP_ONE_RST;
        scaler_cfg.image_width   = IMAGE_WIDTH_RST;
        scaler_cfg.image_height  = IMAGE_HEIGHT_RST;

        add_beat(MODE_WRITE, 0, 0, 24'hFF0080, 0, 0);
        add_beat(MODE_WRITE, 1, 0, 24'h00FF7F, 0, 0);
        add_beat(MODE_WRITE, 0, 1, 24'h123456, 0, 0);
        add_beat(MODE_WRITE, 1, 1, 24'hABCDEF, 0, 0);
        add_beat(MODE_WRITE, 255, 255, 24'hFFFFFF, 0, 0);
        add_beat(MODE_WRITE, 255, 0, 24'h010203, 0, 0);
        add_beat(MODE_WRITE, 255, 1, 24'h0A0B0C, 0, 0);
        add_beat(MODE_WRITE, 5, 5, 24'h5A5A5A, 0, 0);
        add_beat(MODE_WRITE, 6, 5, 24'hA5A5A5, 0, 0);
        add_beat(MODE_WRITE, 5, 6, 24'h3C3C3C, 0, 0);
        add_beat(MODE_WRITE, 6, 6, 24'hC3C3C3, 0, 0);
        add_beat(MODE_WRITE, 4095, 4095, 24'h777777, 0, 0);
        add_beat(MODE_REQUEST, 0, 0, 24'hFFFFFF, 1, 24'hFF0080);
        add_beat(MODE_REQUEST, 255, 255, 24'h000000, 1, 24'hFFFFFF);
        add_beat(MODE_REQUEST, 4095, 4095, 24'hFFFFFF, 1, 24'h000000);
        add_beat(MODE_REQUEST, 5, 5, 24'h000000, 1, 24'h5A5A5A);
        add_cfg(CFG_COLUMN_STEP, 24'h008000);
        add_cfg(CFG_ROW_STEP, 24'h008000);
        add_beat(MODE_REQUEST, 1, 1, 24'h000000, 0, 0);
        add_cfg(CFG_COLUMN_STEP, 24'h0);
        add_cfg(CFG_ROW_STEP, 24'h0);
        add_beat(MODE_REQUEST, 4095, 4095, 24'h000000, 1, 24'hFF0080);
        add_cfg(CFG_COLUMN_STEP, 24'hFFFFFF);
        add_beat(MODE_REQUEST, 1, 0, 24'h000000, 1, 24'h010203);
        add_cfg(CFG_IMAGE_WIDTH, 24'd0);
        add_beat(MODE_REQUEST, 0, 0, 24'h000000, 1, 24'h000000);
        add_cfg(CFG_IMAGE_WIDTH, 24'd4);
        add_cfg(CFG_IMAGE_HEIGHT, 24'd4);
        add_beat(MODE_WRITE, 5, 5, 24'h000000, 0, 0);
        add_cfg(CFG_IMAGE_WIDTH, 24'd511);
        add_cfg(CFG_IMAGE_HEIGHT, 24'd511);
        add_cfg(CFG_COLUMN_STEP, STEP_ONE_RST);
        add_cfg(CFG_ROW_STEP, STEP_ONE_RST);
        add_beat(MODE_REQUEST, 5, 5, 24'h000000, 1, 24'h5A5A5A);
        add_cfg(CFG_REGION_LEFT, 24'd255);
        add_cfg(CFG_REGION_TOP, 24'd255);
        add_beat(MODE_REQUEST, 0, 0, 24'h000000, 1, 24'hFFFFFF);
        add_cfg(CFG_REGION_LEFT, 24'd0);
        add_cfg(CFG_REGION_TOP, 24'd0);
        add_cfg(CFG_REGION_WIDTH, 24'd0);
        add_cfg(CFG_REGION_HEIGHT, 24'd0);
        add_cfg(CFG_COLUMN_STEP, 24'h008000);
        add_cfg(CFG_ROW_STEP, 24'h008000);
        add_beat(MODE_REQUEST, 1, 1, 24'h000000, 1, 24'hFF0080);

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        cfg_open = 1'b0;
        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                if (!cfg_open) settle();
                cfg_open = 1'b1;
                write_reg(script[i].reg_sel, script[i].value);
            end else begin
                if (cfg_open) close_config();
                cfg_open = 1'b0;
                offer_beat(script[i].beat, script[i].typed, script[i].want);
            end
        end

        beats_done = 0;
        phase = 0;
        while (beats_done < RANDOM_BEATS) begin
            settle();
            idle_on = (phase % 3 != 2);
            write_reg(CFG_REGION_LEFT, 24'(pick_origin()));
            write_reg(CFG_REGION_TOP, 24'(pick_origin()));
            write_reg(CFG_REGION_WIDTH, 24'(pick_size()));
            write_reg(CFG_REGION_HEIGHT, 24'(pick_size()));
            write_reg(CFG_COLUMN_STEP, pick_step());
            write_reg(CFG_ROW_STEP, pick_step());
            write_reg(CFG_IMAGE_WIDTH, 24'(pick_size()));
            write_reg(CFG_IMAGE_HEIGHT, 24'(pick_size()));
            close_config();
            phase_beats = $urandom_range(80, 200);
            for (int n = 0; n < phase_beats && beats_done < RANDOM_BEATS; n++) begin
                if (n == phase_beats / 2 && (phase == 0 || $urandom_range(0, 3) == 0))
                    settle();
                it.red_in   = 8'($urandom_range(0, 255));
                it.green_in = 8'($urandom_range(0, 255));
                it.blue_in  = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 99) < 30) begin
                    it.mode   = MODE_WRITE;
                    it.column = write_coord(eff_dim(scaler_cfg.image_width, MAX_IMAGE_WIDTH_DEF));
                    it.row    = write_coord(eff_dim(scaler_cfg.image_height, MAX_IMAGE_HEIGHT_DEF));
                    offer_beat(it, 1'b0, '0);
                end else begin
                    it.mode   = MODE_REQUEST;
                    it.column = request_coord(scaler_cfg.column_step,
                                              eff_dim(scaler_cfg.image_width, MAX_IMAGE_WIDTH_DEF));
                    it.row    = request_coord(scaler_cfg.row_step,
                                              eff_dim(scaler_cfg.image_height, MAX_IMAGE_HEIGHT_DEF));
                    fill_then_request(it);
                end
            end
            phase++;
        end

        settle();
        if (mismatches == 0)
            $display("PASS bilinear_image_scaler_unit");
        else
            $display("FAIL bilinear_image_scaler_unit");
        $finish;
    end

endmodule
